/* design/korselt_carmichael_test_defines.svh */
// assertion macros used by the checker file
`ifndef KORSELT_CARMICHAEL_TEST_DEFINES_SVH
`define KORSELT_CARMICHAEL_TEST_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define KCT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kct check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define KCT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kct check failed");

`endif

/* design/kct_pkg.sv */
// shared constants, types and command/status structs of the carmichael test
package kct_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CAND_WIDTH  = 32;
    localparam int CNT_WIDTH   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // operand pairs fed to the shared divider
    typedef enum logic [1:0] {
        OPS_REST_D  = 2'd0,
        OPS_QUO_D   = 2'd1,
        OPS_NM1_DM1 = 2'd2,
        OPS_NM1_RM1 = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     start;
        div_sel_t sel;
        logic     d_inc;
        logic     save_q;
        logic     take_q;
        logic     set_res;
        logic     res_val;
    } kct_cmd_t;

    typedef struct packed {
        logic reject;
        logic div_done;
        logic quo_lt_d;
        logic rem_zero;
        logic rest_eq_n;
    } kct_stat_t;

endpackage

/* design/kct_cand_if.sv */
// word channel carrying the candidate integer
interface kct_cand_if
    import kct_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [CAND_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);
endinterface

/* design/kct_flag_if.sv */
// word channel carrying the carmichael verdict
interface kct_flag_if;
    logic valid;
    logic ready;
    logic is_carmichael_flag;

    modport source (output valid, output is_carmichael_flag, input ready);
    modport sink (input valid, input is_carmichael_flag, output ready);
endinterface

/* design/kct_divider.sv */
// restoring radix-2 divider, one quotient bit per cycle
module kct_divider
    import kct_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  value_t dividend,
    input  value_t divisor,
    output logic   done,
    output value_t quotient,
    output value_t remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    value_t               quo_reg, quo_next;
    value_t               rem_reg, rem_next;
    value_t               dvs_reg, dvs_next;

    logic [VALUE_WIDTH:0] shifted;
    logic [VALUE_WIDTH:0] diff;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = ~diff[VALUE_WIDTH];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_next = fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_WIDTH'(VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* design/kct_datapath.sv */
// value registers, operand selection and status flags around the divider
module kct_datapath
    import kct_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [CAND_WIDTH-1:0] candidate,
    input  kct_cmd_t                     cmd,
    output kct_stat_t                    stat,
    output logic                         flag
);

    value_t n_reg, n_next;
    value_t rest_reg, rest_next;
    value_t d_reg, d_next;
    value_t q_reg, q_next;
    logic   res_reg, res_next;

    logic signed [63:0] cand_ext;
    value_t             value_in;
    value_t             dividend;
    value_t             divisor;
    logic               div_done;
    value_t             quotient;
    value_t             remainder;

    // low bits of the sign-extended candidate form the tested value
    assign cand_ext = 64'(candidate);
    assign value_in = cand_ext[VALUE_WIDTH-1:0];

    always_comb
    begin
        case (cmd.sel)
            OPS_REST_D:
            begin
                dividend = rest_reg;
                divisor  = d_reg;
            end
            OPS_QUO_D:
            begin
                dividend = quotient;
                divisor  = d_reg;
            end
            OPS_NM1_DM1:
            begin
                dividend = n_reg - 1'b1;
                divisor  = d_reg - 1'b1;
            end
            OPS_NM1_RM1:
            begin
                dividend = n_reg - 1'b1;
                divisor  = rest_reg - 1'b1;
            end
            default:
            begin
                dividend = rest_reg;
                divisor  = d_reg;
            end
        endcase
    end

    kct_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb
    begin
        n_next    = n_reg;
        rest_next = rest_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        res_next  = res_reg;
        if (cmd.load)
        begin
            n_next    = value_in;
            rest_next = value_in;
            d_next    = VALUE_WIDTH'(2);
        end
        if (cmd.d_inc)
        begin
            d_next = d_reg + 1'b1;
        end
        if (cmd.save_q)
        begin
            q_next = quotient;
        end
        if (cmd.take_q)
        begin
            rest_next = q_reg;
            d_next    = VALUE_WIDTH'(2);
        end
        if (cmd.set_res)
        begin
            res_next = cmd.res_val;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rest_reg <= rest_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    assign stat.reject    = value_in[VALUE_WIDTH-1] || (value_in < VALUE_WIDTH'(2));
    assign stat.div_done  = div_done;
    assign stat.quo_lt_d  = quotient < d_reg;
    assign stat.rem_zero  = (remainder == '0);
    assign stat.rest_eq_n = (rest_reg == n_reg);
    assign flag           = res_reg;

endmodule

/* design/kct_controller.sv */
// sequencer for trial division and the korselt checks
module kct_controller
    import kct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  kct_stat_t stat,
    output kct_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_RD    = 7'b0000100,
        ST_QD    = 7'b0001000,
        ST_ND    = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } kct_state_t;

    kct_state_t state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = OPS_REST_D;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.reject)
                    begin
                        cmd.set_res = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                cmd.sel    = OPS_REST_D;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                if (stat.div_done)
                begin
                    if (stat.quo_lt_d)
                    begin
                        // divisor past the square root: rest is the last prime
                        if (stat.rest_eq_n)
                        begin
                            cmd.set_res = 1'b1;
                            state_next  = ST_OUT;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            cmd.sel    = OPS_NM1_RM1;
                            state_next = ST_FIN;
                        end
                    end
                    else if (stat.rem_zero)
                    begin
                        cmd.save_q = 1'b1;
                        cmd.start  = 1'b1;
                        cmd.sel    = OPS_QUO_D;
                        state_next = ST_QD;
                    end
                    else
                    begin
                        cmd.d_inc  = 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_QD:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_zero)
                    begin
                        // square factor
                        cmd.set_res = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.sel    = OPS_NM1_DM1;
                        state_next = ST_ND;
                    end
                end
            end
            ST_ND:
            begin
                if (stat.div_done)
                begin
                    if (!stat.rem_zero)
                    begin
                        cmd.set_res = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        cmd.take_q = 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_FIN:
            begin
                if (stat.div_done)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_val = stat.rem_zero;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/korselt_carmichael_test.sv */
// top level of the carmichael number test by korselt's criterion
// latency: result valid the cycle after taking a negative word or one below 2; otherwise each trial
// divisor takes one division, each factor found two more, and the last cofactor check one more
// throughput: one word at a time; a new word is taken only once the result has been delivered
// reset: rst_n async active low, returns the sequencer to idle with no word pending
// the result word holds in its register until the sink takes it
module korselt_carmichael_test
    import kct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kct_cand_if.sink cand,
    kct_flag_if.source result
);

    // command and status between sequencer and datapath
    kct_cmd_t  cmd;
    kct_stat_t stat;

    // sequencer: walks the trial divisors and decides each check
    //   rest/d   gives both the bound test (quotient < d) and the factor test
    //   q/d      catches a repeated prime factor
    //   (n-1)/(d-1) and (n-1)/(rest-1) apply korselt's divisibility rule
    kct_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cand.valid),
        .in_ready  (cand.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: n, remaining cofactor, trial divisor, saved quotient,
    // result register and the shared divider
    kct_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (cand.candidate),
        .cmd       (cmd),
        .stat      (stat),
        .flag      (result.is_carmichael_flag)
    );

endmodule

/* design/kct_checker.sv */
// port-level checks on the carmichael test handshakes, bound to the top level
`include "korselt_carmichael_test_defines.svh"

module kct_checker (
    input logic clk,
    input logic rst_n,
    input logic cand_valid,
    input logic cand_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_flag
);

    // a taken word closes the input until its result is delivered
    `KCT_ASSERT_NXT(a_busy_after_take, cand_valid && cand_ready, !cand_ready)

    // no new word while a result is pending
    `KCT_ASSERT_IMP(a_no_overlap, res_valid, !cand_ready)

    // one result per word, then back to idle
    `KCT_ASSERT_NXT(a_single_result, res_valid && res_ready, !res_valid && cand_ready)

    // stalled result holds
    `KCT_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_flag))

endmodule

bind korselt_carmichael_test kct_checker u_kct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (cand.valid),
    .cand_ready (cand.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_flag   (result.is_carmichael_flag)
);
